>>> rtl/wpkdh_pkg.sv
package wpkdh_pkg;

  // port widths fixed by the interface
  localparam int OUT_KEY_W  = 32;
  localparam int OUT_SLOT_W = 16;
  localparam int ATTEMPT_W  = 16;
  localparam int M_W        = 16;
  localparam int RADIX_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 1'b1;

  localparam logic [M_W-1:0]     TABLE_RESET = 16'd11;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd53;

  // request function codes
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_END   = 2'd1;
  localparam logic [1:0] FUNC_PROBE = 2'd2;

  // document bytes with a special meaning
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // result kinds
  localparam logic KIND_END   = 1'b0;
  localparam logic KIND_PROBE = 1'b1;

  // command queue depth, a power of two
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_DELIM,
    OP_END,
    OP_PROBE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [7:0]           char_byte;
    logic [ATTEMPT_W-1:0] attempt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MOD1,
    B_MOD2,
    B_PSUM,
    B_PMOD,
    B_PUSH
  } back_state_t;

endpackage

>>> rtl/word_polynomial_key_double_hash_unit.sv
// Document key and double-hash slot unit.
// Input channel (in_valid/in_ready): in_func selects a document byte
// (in_char_byte), an end of document, or a probe request for attempt
// in_attempt. Space, comma and period close a word; newline is skipped.
// Result channel (out_valid/out_ready): one result per end-of-document or
// probe request, none for bytes. Configuration (cfg_we/cfg_index/cfg_wdata)
// sets table size and radix; the user writes it only while the unit is idle,
// and the unit itself does not enforce this. Requests pass through a two-entry
// command queue into the execution side. Byte requests sustain one per cycle
// while the execution side is idle; the Horner multiply-add is combinational.
// End of document and probe use the one-bit-per-cycle remainder unit of
// width DW = max(KEY_WIDTH, SLOT_WIDTH+17) (33 at default widths), run twice
// for the key and once for the probe slot. The result waits in an output
// register while out_ready is low; the queue keeps accepting requests until
// it fills. Synchronous reset clears the accumulators, the saved slot (0) and
// step (1), the queue and the output valid, and loads table size 11 and radix 53.
module word_polynomial_key_double_hash_unit import wpkdh_pkg::*; #(
  parameter int KEY_WIDTH  = 32,
  parameter int SLOT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_char_byte,
  input  logic [ATTEMPT_W-1:0]  in_attempt,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_result_kind,
  output logic [OUT_KEY_W-1:0]  out_doc_key,
  output logic [OUT_SLOT_W-1:0] out_first_slot,
  output logic [OUT_SLOT_W-1:0] out_probe_step,
  output logic [OUT_SLOT_W-1:0] out_slot
);

  logic [M_W-1:0]     table_size_r, table_size_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  q_stat_t            q_stat;
  logic               q_push;
  logic               q_pop;
  cmd_t               q_in_cmd;
  cmd_t               q_head_cmd;

  // configuration register decode
  always_comb begin
    table_size_nxt = table_size_r;
    radix_nxt      = radix_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_SIZE: table_size_nxt = cfg_wdata[M_W-1:0];
        REG_RADIX:      radix_nxt      = cfg_wdata[RADIX_W-1:0];
        default:        table_size_nxt = table_size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_RESET;
      radix_r      <= RADIX_RESET;
    end else begin
      table_size_r <= table_size_nxt;
      radix_r      <= radix_nxt;
    end
  end

  // request intake and classification
  wpkdh_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_char_byte (in_char_byte),
    .in_attempt   (in_attempt),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_cmd        (q_in_cmd)
  );

  // command queue between intake and execution
  wpkdh_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .stat     (q_stat)
  );

  // execution side
  wpkdh_back #(
    .KEY_WIDTH  (KEY_WIDTH),
    .SLOT_WIDTH (SLOT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .table_size      (table_size_r),
    .radix           (radix_r),
    .q_stat          (q_stat),
    .q_cmd           (q_head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_doc_key     (out_doc_key),
    .out_first_slot  (out_first_slot),
    .out_probe_step  (out_probe_step),
    .out_slot        (out_slot)
  );

endmodule

>>> rtl/wpkdh_front.sv
module wpkdh_front import wpkdh_pkg::*; (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [7:0]           in_char_byte,
  input  logic [ATTEMPT_W-1:0] in_attempt,
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic keep;

  // take a request whenever the queue has room
  assign in_ready = !q_stat.full;

  // classify the request; newlines and the unused code are dropped here
  always_comb begin
    keep              = 1'b1;
    q_cmd.op          = OP_CHAR;
    q_cmd.char_byte   = in_char_byte;
    q_cmd.attempt     = in_attempt;
    unique case (in_func)
      FUNC_BYTE: begin
        case (in_char_byte) inside
          CHAR_SPACE, CHAR_COMMA, CHAR_PERIOD: q_cmd.op = OP_DELIM;
          CHAR_NEWLINE:                        keep = 1'b0;
          default:                             q_cmd.op = OP_CHAR;
        endcase
      end
      FUNC_END:   q_cmd.op = OP_END;
      FUNC_PROBE: q_cmd.op = OP_PROBE;
      default:    keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

>>> rtl/wpkdh_cmd_q.sv
module wpkdh_cmd_q import wpkdh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("command queue read while empty");
`endif

endmodule

>>> rtl/wpkdh_rem.sv
module wpkdh_rem import wpkdh_pkg::*; #(
  parameter int DW = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [M_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [M_W-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r;
  logic [M_W-1:0] dvs_r;
  logic [M_W-1:0] rem_r, rem_nxt;
  logic [M_W:0]  trial;
  logic [M_W:0]  diff;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, dvd_r[DW-1]};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[M_W-1:0] : trial[M_W-1:0];
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
    end else if (busy_r) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit started while busy");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("remainder not below divisor");
`endif

endmodule

>>> rtl/wpkdh_back.sv
module wpkdh_back import wpkdh_pkg::*; #(
  parameter int KEY_WIDTH  = 32,
  parameter int SLOT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [M_W-1:0]        table_size,
  input  logic [RADIX_W-1:0]    radix,
  input  q_stat_t               q_stat,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_result_kind,
  output logic [OUT_KEY_W-1:0]  out_doc_key,
  output logic [OUT_SLOT_W-1:0] out_first_slot,
  output logic [OUT_SLOT_W-1:0] out_probe_step,
  output logic [OUT_SLOT_W-1:0] out_slot
);

  localparam int PROD_W = SLOT_WIDTH + ATTEMPT_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DW     = (KEY_WIDTH > SUM_W) ? KEY_WIDTH : SUM_W;

  back_state_t           state_r, state_nxt;
  logic                  kind_r;
  logic [KEY_WIDTH-1:0]  word_acc_r;
  logic [KEY_WIDTH-1:0]  doc_acc_r;
  logic [SLOT_WIDTH-1:0] saved_first_r;
  logic [SLOT_WIDTH-1:0] saved_step_r;
  logic [M_W-1:0]        first_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  out_valid_r;

  logic                  head_go;
  logic                  slot_free;
  logic                  push;
  logic [KEY_WIDTH-1:0]  horner;
  logic                  rem_start;
  logic [DW-1:0]         rem_dividend;
  logic [M_W-1:0]        rem_divisor;
  logic                  rem_busy;
  logic                  rem_done;
  logic [M_W-1:0]        rem_val;

  logic [M_W-1:0]        end_first;
  logic [M_W:0]          end_step;
  logic [SLOT_WIDTH-1:0] end_first_s;
  logic [SLOT_WIDTH-1:0] end_step_s;
  logic [SLOT_WIDTH-1:0] probe_slot_s;

  assign head_go   = (state_r == B_IDLE) && !q_stat.empty;
  assign q_pop     = head_go;
  assign slot_free = !out_valid_r || out_ready;
  assign push      = (state_r == B_PUSH) && slot_free;

  // word key step: acc * radix + byte
  assign horner = word_acc_r * KEY_WIDTH'(radix) + KEY_WIDTH'(q_cmd.char_byte);

  // shared iterative remainder
  wpkdh_rem #(
    .DW (DW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (head_go && q_cmd.op == OP_END) begin
          state_nxt = B_MOD1;
        end else if (head_go && q_cmd.op == OP_PROBE) begin
          state_nxt = B_PSUM;
        end
      end
      B_MOD1: if (rem_done) state_nxt = B_MOD2;
      B_MOD2: if (rem_done) state_nxt = B_PUSH;
      B_PSUM: state_nxt = B_PMOD;
      B_PMOD: if (rem_done) state_nxt = B_PUSH;
      B_PUSH: if (slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // remainder unit requests per state
  always_comb begin
    rem_start    = 1'b0;
    rem_dividend = DW'(doc_acc_r);
    rem_divisor  = table_size;
    unique case (state_r)
      B_IDLE: rem_start = head_go && (q_cmd.op == OP_END);
      B_MOD1: begin
        rem_start   = rem_done;
        rem_divisor = M_W'(table_size - 1'b1);
      end
      B_PSUM: begin
        rem_start    = 1'b1;
        rem_dividend = DW'(SUM_W'(prod_r) + SUM_W'(saved_first_r));
      end
      B_MOD2, B_PMOD, B_PUSH: rem_start = 1'b0;
      default: rem_start = 1'b0;
    endcase
  end

  // end-of-document slot and step, probe slot
  always_comb begin
    end_first    = (table_size == '0) ? '0 : first_r;
    end_step     = (table_size >= M_W'(2)) ? ({1'b0, rem_val} + 1'b1) : (M_W + 1)'(1);
    end_first_s  = SLOT_WIDTH'(end_first);
    end_step_s   = SLOT_WIDTH'(end_step);
    probe_slot_s = (table_size == '0) ? '0 : SLOT_WIDTH'(rem_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // accumulators and saved probe values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_acc_r    <= '0;
      doc_acc_r     <= '0;
      saved_first_r <= '0;
      saved_step_r  <= SLOT_WIDTH'(1);
      kind_r        <= KIND_END;
      out_valid_r   <= 1'b0;
    end else begin
      if (head_go) begin
        case (q_cmd.op)
          OP_CHAR:  word_acc_r <= horner;
          OP_DELIM: begin
            doc_acc_r  <= doc_acc_r + word_acc_r;
            word_acc_r <= '0;
          end
          OP_END:   kind_r <= KIND_END;
          default:  kind_r <= KIND_PROBE;
        endcase
      end
      if (push && kind_r == KIND_END) begin
        saved_first_r <= end_first_s;
        saved_step_r  <= end_step_s;
        doc_acc_r     <= '0;
        word_acc_r    <= '0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (head_go && q_cmd.op == OP_PROBE) begin
      prod_r <= PROD_W'(q_cmd.attempt) * PROD_W'(saved_step_r);
    end
    if (state_r == B_MOD1 && rem_done) begin
      first_r <= rem_val;
    end
    if (push) begin
      out_result_kind <= kind_r;
      if (kind_r == KIND_END) begin
        out_doc_key    <= OUT_KEY_W'(doc_acc_r);
        out_first_slot <= OUT_SLOT_W'(end_first_s);
        out_probe_step <= OUT_SLOT_W'(end_step_s);
        out_slot       <= OUT_SLOT_W'(end_first_s);
      end else begin
        out_doc_key    <= '0;
        out_first_slot <= OUT_SLOT_W'(saved_first_r);
        out_probe_step <= OUT_SLOT_W'(saved_step_r);
        out_slot       <= OUT_SLOT_W'(probe_slot_s);
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_PUSH && !slot_free) |=> (state_r == B_PUSH))
    else $error("result dropped while output stalled");
  a_rem_idle_at_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_PUSH || state_r == B_IDLE) |-> !rem_busy)
    else $error("remainder unit busy outside a computation");
`endif

endmodule
